### rtl/core/bcda_pkg.sv
// Shared types, widths and constants for the binary to decimal ASCII converter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bcda_pkg;

  localparam int unsigned VALUE_W    = 32;
  // Decimal digits of the widest 32-bit value: one chain cell per digit.
  localparam int unsigned NUM_DIGITS = 10;
  // Digit buffer depth; runs are cut to this many least significant digits.
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned STEP_W     = VALUE_W + 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  // Word handed from cell to cell along the chain.
  typedef struct packed {
    logic [VALUE_W-1:0]            rem;     // part of the value not yet turned into digits
    logic [NUM_DIGITS*DIGIT_W-1:0] digits;  // digit of cell k at slice k, most significant first
    logic [CNT_W-1:0]              count;   // digits in the text, zero until the first nonzero
  } bcda_word_t;

  function automatic logic [STEP_W-1:0] pow10(input int unsigned e);
    logic [STEP_W-1:0] p;
    p = STEP_W'(1);
    for (int unsigned i = 0; i < e; i++) begin
      p = STEP_W'(p * STEP_W'(10));
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### rtl/core/bcda_if.sv
// Stream interfaces of the converter: binary value in, ASCII digit out.
// Depends on bcda_pkg for the field widths.
`default_nettype none

interface bcda_in_if import bcda_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bcda_out_if import bcda_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic [CNT_W-1:0]  digit_count;
  logic              last;

  modport source (output valid, output digit_char, output digit_count, output last,
                  input ready);
  modport sink   (input valid, input digit_char, input digit_count, input last,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter: cell chain plus serializer.
// Depends on bcda_pkg, bcda_if, bcda_cell and bcda_emit.
//
//   channel | dir | payload                              | handshake
//   --------+-----+--------------------------------------+------------
//   in_i    | in  | value[31:0]                          | valid/ready
//   out_o   | out | digit_char[5:0] digit_count[3:0] last| valid/ready
//
// Flow: a value passes ten digit cells, each registered, and then loads the
//   serializer register; the serializer then sends one digit word per cycle
//   while out_o.ready is high, one word per digit of the value, and the output
//   port sets the sustained rate.
// Reset: rst_ni clears only the valid flags of the cells and the serializer.
// Stalls: out_o.ready low holds the serializer; the chain keeps filling until
//   every cell holds a word, and only then in_i.ready drops.
`default_nettype none

module binary_to_decimal_ascii import bcda_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bcda_in_if.sink     in_i,
  bcda_out_if.source  out_o
);

  // Chain links: link k feeds cell k, link NUM_DIGITS feeds the serializer.
  logic       link_valid [NUM_DIGITS+1];
  logic       link_ready [NUM_DIGITS+1];
  bcda_word_t link_word  [NUM_DIGITS+1];

  // Enter with the whole value as remainder and no digits found yet.
  assign link_valid[0] = in_i.valid;
  assign in_i.ready    = link_ready[0];
  assign link_word[0]  = '{rem: in_i.value, digits: '0, count: '0};

  // Cell k settles the digit for 10^(9-k) and hands the rest on.
  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    bcda_cell #(
      .POS (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (link_valid[k]),
      .in_ready_o  (link_ready[k]),
      .in_word_i   (link_word[k]),
      .out_valid_o (link_valid[k+1]),
      .out_ready_i (link_ready[k+1]),
      .out_word_o  (link_word[k+1])
    );
  end

  // Drop the leading zeros and send the remaining digits, most significant first.
  bcda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (link_valid[NUM_DIGITS]),
    .in_ready_o  (link_ready[NUM_DIGITS]),
    .in_word_i   (link_word[NUM_DIGITS]),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.digit_char),
    .out_count_o (out_o.digit_count),
    .out_last_o  (out_o.last)
  );

endmodule

`default_nettype wire

### rtl/core/bcda_cell.sv
// One chain cell: extracts the decimal digit for one power of ten.
// Depends on bcda_pkg for the word type and the pow10 function.
`default_nettype none

module bcda_cell import bcda_pkg::*; #(
  parameter int unsigned POS = 0
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire bcda_word_t in_word_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output bcda_word_t      out_word_o
);

  localparam int unsigned EXP = NUM_DIGITS - 1 - POS;
  localparam logic [STEP_W-1:0] PWR = pow10(EXP);

  logic              valid_q;
  bcda_word_t        word_q, word_d;
  logic [DIGIT_W-1:0] digit;
  logic [STEP_W-1:0]  sub;
  logic [STEP_W-1:0]  rem_ext;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  // Pick the largest multiple of the power that fits, then take it off.
  always_comb begin
    rem_ext = STEP_W'(in_word_i.rem);
    digit   = '0;
    sub     = '0;
    for (int unsigned j = 1; j < 10; j++) begin
      if (rem_ext >= STEP_W'(PWR * STEP_W'(j))) begin
        digit = DIGIT_W'(j);
        sub   = STEP_W'(PWR * STEP_W'(j));
      end
    end
    word_d        = in_word_i;
    word_d.rem    = VALUE_W'(rem_ext - sub);
    word_d.digits[POS*DIGIT_W +: DIGIT_W] = digit;
    if (in_word_i.count == '0 && (digit != '0 || POS == NUM_DIGITS - 1)) begin
      word_d.count = CNT_W'(NUM_DIGITS - POS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= word_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bcda_emit.sv
// Serializer at the end of the chain: sends one ASCII digit word per cycle while out_ready_i is high.
// Depends on bcda_pkg for the word type and widths.
`default_nettype none

module bcda_emit import bcda_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire bcda_word_t     in_word_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [CHAR_W-1:0]   out_char_o,
  output logic [CNT_W-1:0]    out_count_o,
  output logic                out_last_o
);

  localparam logic [CNT_W-1:0] MAX_CNT =
    CNT_W'((MAX_DIGITS < NUM_DIGITS) ? MAX_DIGITS : NUM_DIGITS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGITS - 1);

  logic                          valid_q;
  logic [NUM_DIGITS*DIGIT_W-1:0] digits_q;
  logic [CNT_W-1:0]              count_q;
  logic [IDX_W-1:0]              idx_q;
  logic [CNT_W-1:0]              cnt_eff;
  logic [DIGIT_W-1:0]            digit;
  logic                          load;

  assign out_last_o  = (idx_q == LAST_IDX);
  assign in_ready_o  = !valid_q || (out_ready_i && out_last_o);
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_count_o = count_q;
  assign digit       = digits_q[idx_q*DIGIT_W +: DIGIT_W];
  assign out_char_o  = ASCII_ZERO + CHAR_W'(digit);

  // Keep only the buffer's worth of low digits.
  assign cnt_eff = (in_word_i.count > MAX_CNT) ? MAX_CNT : in_word_i.count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      digits_q <= in_word_i.digits;
      count_q  <= cnt_eff;
      idx_q    <= IDX_W'(CNT_W'(NUM_DIGITS) - cnt_eff);
    end else if (valid_q && out_ready_i && !out_last_o) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/core/bcda_checker.sv
// Port-level assertions for binary_to_decimal_ascii and the bind that attaches them.
// Depends on bcda_pkg for widths and constants.
`default_nettype none

module bcda_checker import bcda_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [CHAR_W-1:0] digit_char_i,
  input wire logic [CNT_W-1:0]  digit_count_i,
  input wire logic              last_i
);

  // A stalled digit word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(digit_char_i) && $stable(digit_count_i) && $stable(last_i))
    else $error("digit word changed under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> digit_char_i >= ASCII_ZERO && digit_char_i <= ASCII_ZERO + CHAR_W'(9))
    else $error("digit_char outside '0'..'9'");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> digit_count_i != '0 && digit_count_i <= CNT_W'(NUM_DIGITS))
    else $error("digit_count out of range");

  // A run continues without a gap and keeps its count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=>
      out_valid_i && digit_count_i == $past(digit_count_i))
    else $error("run broken or count changed mid-run");

endmodule

bind binary_to_decimal_ascii bcda_checker u_bcda_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .digit_char_i  (out_o.digit_char),
  .digit_count_i (out_o.digit_count),
  .last_i        (out_o.last)
);

`default_nettype wire

### sim/binary_to_decimal_ascii_tb.sv
// Self-checking testbench for binary_to_decimal_ascii: values in, ASCII digit words out.
// Depends on bcda_pkg, bcda_if and the block's RTL; holds its own digit predictor.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;
  import bcda_pkg::*;

  // Chance in percent that either side idles, outside a no-idle stretch.
  localparam int unsigned IDLE_PCT        = 17;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT  = 1000;
  // Wait at the end, once no words are owed, for stray words.
  localparam int unsigned DRAIN_CYCLES    = 16;
  // Scratch depth for the digit split; wider than any 32-bit value needs.
  localparam int unsigned DIGIT_BUF_DEPTH = 20;
  localparam int unsigned LENGTH_ITEMS    = 250;
  localparam int unsigned BURST_ITEMS     = 80;
  localparam int unsigned FULL_ITEMS      = 80;

  // One digit word as it leaves the block.
  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic [CNT_W-1:0]  digit_count;
    logic              last;
  } digit_word_t;

  logic clk_i;
  logic rst_ni;

  bcda_in_if  in_if ();
  bcda_out_if out_if ();

  binary_to_decimal_ascii u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Digit words still owed by the block, oldest first.
  digit_word_t pending_digits[$];
  int unsigned mismatch_count = 0;
  // Set during a stretch in which neither side idles.
  bit          no_idle = 1'b0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Split a value into decimal digits and queue the words it must produce:
  // most significant digit first, no leading zeros, zero gives a lone '0'.
  // Keep at most MAX_DIGITS low digits; with 32-bit values that never bites.
  function automatic void predict_digits(input logic [VALUE_W-1:0] v);
    logic [DIGIT_W-1:0] digit_buf [DIGIT_BUF_DEPTH];
    logic [VALUE_W-1:0] rest;
    int unsigned        n;
    digit_word_t        w;
    rest = v;
    n    = 0;
    do begin
      digit_buf[n] = DIGIT_W'(rest % 10);
      rest         = rest / 10;
      n++;
    end while (rest != 0 && n < DIGIT_BUF_DEPTH);
    if (n > MAX_DIGITS) n = MAX_DIGITS;
    for (int unsigned k = 0; k < n; k++) begin
      w.digit_char  = CHAR_W'(ASCII_ZERO + CHAR_W'(digit_buf[n - 1 - k]));
      w.digit_count = CNT_W'(n);
      w.last        = (k == n - 1);
      pending_digits.push_back(w);
    end
  endfunction

  // Offer one value and hold it until the block takes it. Idle first at random:
  // drop valid for a cycle at a time. The prediction is queued at the accepting
  // edge. Valid stays high on return so that back-to-back words need no gap.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk_i); while (!in_if.ready);
    predict_digits(v);
  endtask

  // Corner values: zero, single digits, the low end of every digit count and the
  // high end of most, zeros in the middle of a run, the largest value and alternating bits.
  task automatic test_directed();
    logic [VALUE_W-1:0] corner_values [25] = '{
      32'd0, 32'd1, 32'd5, 32'd9, 32'd10,
      32'd19, 32'd99, 32'd100, 32'd999, 32'd1000,
      32'd10000, 32'd99999, 32'd100000, 32'd1000000, 32'd9999999,
      32'd10000000, 32'd99999999, 32'd100000000, 32'd999999999, 32'd1000000000,
      32'd1000000007, 32'd3000000000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
    };
    foreach (corner_values[i]) send_value(corner_values[i]);
  endtask

  // Pick a digit count first, then a value of exactly that many digits, so that
  // short runs are as common as long ones; plain random values are nearly all
  // ten digits long.
  task automatic test_digit_lengths();
    int unsigned        len;
    longint unsigned    lo;
    longint unsigned    hi;
    for (int unsigned i = 0; i < LENGTH_ITEMS; i++) begin
      len = $urandom_range(1, 10);
      lo  = 1;
      for (int unsigned k = 1; k < len; k++) lo = lo * 10;
      hi  = lo * 10 - 1;
      if (len == 1) lo = 0;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      send_value($urandom_range(32'(hi), 32'(lo)));
    end
  endtask

  // Long stretch with no idling on either side: the output runs flat out and
  // the chain has to back up into the input.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int unsigned i = 0; i < BURST_ITEMS; i++) begin
      if (i % 4 == 0) send_value($urandom_range(9, 0));
      else            send_value($urandom());
    end
    no_idle = 1'b0;
  endtask

  // Uniform 32-bit values with random idling again.
  task automatic test_full_range();
    for (int unsigned i = 0; i < FULL_ITEMS; i++) send_value($urandom());
  endtask

  // Output side: stall at random, never during the no-idle stretch.
  always @(posedge clk_i) begin
    out_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each accepted digit word with the oldest one owed.
  always @(posedge clk_i) begin
    digit_word_t got;
    digit_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.digit_char, out_if.digit_count, out_if.last};
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected word char=%0d count=%0d last=%0b",
                 $time, got.digit_char, got.digit_count, got.last);
        mismatch_count++;
      end else begin
        want = pending_digits.pop_front();
        if (got.digit_char !== want.digit_char || got.digit_count !== want.digit_count ||
            got.last !== want.last) begin
          $display("%0t: mismatch exp char=%0d count=%0d last=%0b, act char=%0d count=%0d last=%0b",
                   $time, want.digit_char, want.digit_count, want.last,
                   got.digit_char, got.digit_count, got.last);
          mismatch_count++;
        end
      end
    end
  end

  // Hang detection: count cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("binary_to_decimal_ascii_tb: errors");
      $finish;
    end
  end

  initial begin
    // Hold reset and the input channel at known values, then release reset.
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_digit_lengths();
    test_back_to_back();
    test_full_range();
    in_if.valid <= 1'b0;

    // Wait for every owed word, then a little longer to catch extra ones.
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("binary_to_decimal_ascii_tb: clean");
    end else begin
      $display("binary_to_decimal_ascii_tb: errors");
    end
    $finish;
  end

endmodule
